// ----- hw/rtl/bas_pkg.sv -----
package bas_pkg;

   localparam logic [63:0] SGN_BIT  = 64'h8000000000000000;
   localparam logic [63:0] EXP_MASK = 64'h7FF0000000000000;
   localparam logic [63:0] FRC_MASK = 64'h000FFFFFFFFFFFFF;
   localparam logic [63:0] QNAN_BIT = 64'h0008000000000000;
   localparam logic [10:0] EXP_MAX  = 11'h7FF;

   typedef struct packed {
      logic        op;
      logic [63:0] a_bits;
      logic [63:0] b_bits;
   } req_type;

   typedef struct packed {
      logic [63:0] sum_bits;
   } rsp_type;

endpackage

// ----- hw/rtl/bas_stream_if.sv -----
interface bas_req_if;
   logic             valid;
   logic             ready;
   bas_pkg::req_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface bas_rsp_if;
   logic             valid;
   logic             ready;
   bas_pkg::rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// ----- hw/rtl/binary64_add_sub.sv -----
// Pipelined binary64 adder and subtractor, round to nearest even. One operand
// pair is taken per cycle while the output is not stalled, and each result
// passes through four register stages: operand swap and alignment, the
// significand add, leading-zero normalization, and rounding. A stalled
// output holds the whole pipeline, so back pressure costs no items.
module binary64_add_sub (
   input  logic  clock,
   input  logic  reset,
   bas_req_if.sink   req,
   bas_rsp_if.source rsp
);

   logic adv;
   logic [3:0] vld_ff;
   assign adv = !vld_ff[3] || rsp.ready;
   assign req.ready = adv;

   // Stage 1: special cases, swap, alignment.
   logic [63:0] a, b, x, y;
   logic        sp1_in, sx, sy;
   logic [63:0] spv1_in;
   logic [10:0] ex, ey, d;
   logic [55:0] mx, my, sm;
   logic [55:0] mx1_ff, sm1_ff;
   logic        sub1_ff, sp1_ff, sgn1_ff, zs1_ff;
   logic [10:0] ex1_ff;
   logic [63:0] spv1_ff;
   logic        an, bn, ai, bi;

   always_comb begin
      a = req.data.a_bits;
      b = req.data.b_bits ^ (req.data.op ? bas_pkg::SGN_BIT : 64'd0);
      an = (a[62:52] == bas_pkg::EXP_MAX) && (a[51:0] != 52'd0);
      bn = (b[62:52] == bas_pkg::EXP_MAX) && (b[51:0] != 52'd0);
      ai = a[62:0] == bas_pkg::EXP_MASK[62:0];
      bi = b[62:0] == bas_pkg::EXP_MASK[62:0];
      sp1_in = 1'b1;
      priority if (an) spv1_in = a | bas_pkg::QNAN_BIT;
      else if (bn) spv1_in = b | bas_pkg::QNAN_BIT;
      else if (ai && bi && (a[63] != b[63]))
         spv1_in = bas_pkg::EXP_MASK | bas_pkg::QNAN_BIT;
      else if (ai) spv1_in = a;
      else if (bi) spv1_in = b;
      else begin
         spv1_in = 64'd0;
         sp1_in = 1'b0;
      end
      if (b[62:0] > a[62:0]) begin
         x = b; y = a;
      end else begin
         x = a; y = b;
      end
      sx = x[63];
      sy = y[63];
      ex = (x[62:52] == 11'd0) ? 11'd1 : x[62:52];
      ey = (y[62:52] == 11'd0) ? 11'd1 : y[62:52];
      mx = {x[62:52] != 11'd0, x[51:0], 3'b000};
      my = {y[62:52] != 11'd0, y[51:0], 3'b000};
      d = ex - ey;
      if (d >= 11'd58) sm = {55'd0, my != 56'd0};
      else sm = (my >> d[5:0]) | {55'd0, (my & ((56'd1 << d[5:0]) - 56'd1)) != 56'd0};
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         mx1_ff <= mx;
         sm1_ff <= sm;
         sub1_ff <= sx != sy;
         sp1_ff <= sp1_in;
         spv1_ff <= spv1_in;
         sgn1_ff <= sx;
         zs1_ff <= sx & sy;
         ex1_ff <= ex;
      end
   end

   // Stage 2: add.
   logic [56:0] r2_ff;
   logic        sp2_ff, sgn2_ff, zs2_ff;
   logic [63:0] spv2_ff;
   logic [10:0] ex2_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         r2_ff <= sub1_ff ? ({1'b0, mx1_ff} - {1'b0, sm1_ff})
                          : ({1'b0, mx1_ff} + {1'b0, sm1_ff});
         sp2_ff <= sp1_ff;
         spv2_ff <= spv1_ff;
         sgn2_ff <= sgn1_ff;
         zs2_ff <= zs1_ff;
         ex2_ff <= ex1_ff;
      end
   end

   // Stage 3: normalize.
   logic [55:0] r3_in, r3_ff;
   logic [11:0] e3_in, e3_ff;
   logic [5:0]  lz;
   logic [11:0] sh;
   logic        sp3_ff, zero3_ff;
   logic [63:0] spv3_ff;
   logic        sgn3_ff, zs3_ff;

   always_comb begin
      lz = 6'd56;
      sh = 12'd0;
      for (int i = 0; i <= 55; i++) begin
         if (r2_ff[i]) lz = 6'(55 - i);
      end
      if (r2_ff[56]) begin
         r3_in = r2_ff[56:1] | {55'd0, r2_ff[0]};
         e3_in = {1'b0, ex2_ff} + 12'd1;
      end else begin
         sh = {6'd0, lz};
         if (sh > {1'b0, ex2_ff} - 12'd1) sh = {1'b0, ex2_ff} - 12'd1;
         r3_in = r2_ff[55:0] << sh[5:0];
         e3_in = {1'b0, ex2_ff} - sh;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         r3_ff <= r3_in;
         e3_ff <= e3_in;
         sp3_ff <= sp2_ff;
         spv3_ff <= spv2_ff;
         sgn3_ff <= sgn2_ff;
         zs3_ff <= zs2_ff;
         zero3_ff <= r2_ff == 57'd0;
      end
   end

   // Stage 4: round and pack.
   logic [53:0] q;
   logic [11:0] e4;
   logic [63:0] res_in, res_ff;
   always_comb begin
      q = {1'b0, r3_ff[55:3]};
      if (r3_ff[2] && ((r3_ff[1:0] != 2'd0) || r3_ff[3])) q = q + 54'd1;
      e4 = e3_ff;
      if (q[53]) begin
         q = q >> 1;
         e4 = e4 + 12'd1;
      end
      priority if (sp3_ff) res_in = spv3_ff;
      else if (zero3_ff) res_in = {zs3_ff, 63'd0};
      else if (e4 >= 12'h7FF) res_in = {sgn3_ff, bas_pkg::EXP_MASK[62:0]};
      else res_in = {sgn3_ff, q[52] ? e4[10:0] : 11'd0, q[51:0]};
   end

   always_ff @(posedge clock) begin
      if (reset) vld_ff <= 4'd0;
      else if (adv) vld_ff <= {vld_ff[2:0], req.valid};
      if (adv) res_ff <= res_in;
   end

   assign rsp.valid = vld_ff[3];
   assign rsp.data.sum_bits = res_ff;

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ready |=> rsp.valid && $stable(res_ff))
      else $error("result changed under stall");
   a_take: assert property (@(posedge clock) disable iff (reset)
      req.valid && req.ready |=> vld_ff[0])
      else $error("accepted item lost");
   a_norm: assert property (@(posedge clock) disable iff (reset)
      vld_ff[2] && !sp3_ff && !zero3_ff |-> r3_ff[55] || (e3_ff == 12'd1))
      else $error("normalization slip");

endmodule
